[rtl/core/lsbf_pkg.sv]
`default_nettype none

package lsbf_pkg;

    localparam int PANEL_WIDTH     = 60;
    localparam int LINES_PER_STRIP = 2;
    localparam int STRIP_COUNT     = 8;

    localparam int STORE_DEPTH  = PANEL_WIDTH * LINES_PER_STRIP * STRIP_COUNT;
    localparam int STRIP_STRIDE = PANEL_WIDTH * LINES_PER_STRIP;
    localparam int COLOR_BITS   = 24;
    localparam int INDEX_BITS   = 10;
    localparam int BYTE_BITS    = 8;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SUM_W  = ADDR_W + 1;
    localparam int K_W    = (PANEL_WIDTH > 1) ? $clog2(PANEL_WIDTH) : 1;
    localparam int Y_W    = (LINES_PER_STRIP > 1) ? $clog2(LINES_PER_STRIP) : 1;
    localparam int FCNT_W = $clog2(STRIP_COUNT);
    localparam int BCNT_W = $clog2(COLOR_BITS);

    localparam logic [23:0] RED_MASK   = 24'hFF0000;
    localparam logic [23:0] GREEN_MASK = 24'h00FF00;
    localparam logic [23:0] BLUE_MASK  = 24'h0000FF;

    typedef logic [COLOR_BITS-1:0] color_t;

    typedef struct packed {
        logic capture;
        logic emit;
        logic last_of_group;
        logic last_of_frame;
    } lsbf_ctrl_t;

    function automatic color_t to_grb(input color_t c);
        return ((c & RED_MASK) >> 8) | ((c & GREEN_MASK) << 8) | (c & BLUE_MASK);
    endfunction

endpackage

`default_nettype wire

[rtl/core/led_strip_bitplane_formatter_unit.sv]
// Channel   Dir  tdata                                  tuser / tlast
// s_axis    in   [9:0] pixel_index, [33:10] pixel_color  tuser: kind
// m_axis    out  [7:0] plane_byte                        tlast: last_of_group,
//                                                        tuser: last_of_frame
// cfg       in   cfg_wr_data: reverse_first_row
//
// Pixel write: the store is written as the item is accepted. Group item:
// accept, setup, 8 store reads through the one adder and read port, one
// drain, 24 bytes, plus output stalls. After reset the store is cleared,
// with s_axis_tready low. An output stall holds the byte sequencer in place.
`default_nettype none

module led_strip_bitplane_formatter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // [9:0] pixel_index, [33:10] pixel_color
    input  wire logic        s_axis_tuser,  // [0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] plane_byte
    output logic             m_axis_tlast,
    output logic             m_axis_tuser   // [0] last_of_frame
);

    import lsbf_pkg::*;

    logic                  can_load;
    logic                  ram_wr_en;
    logic [ADDR_W-1:0]     ram_wr_addr;
    logic [COLOR_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [ADDR_W-1:0]     ram_rd_addr;
    logic [COLOR_BITS-1:0] ram_rd_data;
    lsbf_ctrl_t            ctrl;

    lsbf_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_kind     (s_axis_tuser),
        .in_index    (s_axis_tdata[INDEX_BITS-1:0]),
        .in_color    (s_axis_tdata[INDEX_BITS+COLOR_BITS-1:INDEX_BITS]),
        .can_load    (can_load),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ctrl        (ctrl)
    );

    lsbf_ram #(
        .WIDTH (COLOR_BITS),
        .DEPTH (STORE_DEPTH),
        .AW    (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lsbf_plane u_plane (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .rd_data        (ram_rd_data),
        .can_load       (can_load),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_byte       (m_axis_tdata),
        .out_last_group (m_axis_tlast),
        .out_last_frame (m_axis_tuser)
    );

endmodule

`default_nettype wire

[rtl/core/lsbf_ram.sv]
`default_nettype none

module lsbf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 960,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/lsbf_seq.sv]
`default_nettype none

module lsbf_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_wr_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        in_kind,
    input  wire logic [lsbf_pkg::INDEX_BITS-1:0] in_index,
    input  wire logic [lsbf_pkg::COLOR_BITS-1:0] in_color,
    input  wire logic                        can_load,
    output logic                             ram_wr_en,
    output logic [lsbf_pkg::ADDR_W-1:0]      ram_wr_addr,
    output logic [lsbf_pkg::COLOR_BITS-1:0]  ram_wr_data,
    output logic                             ram_rd_en,
    output logic [lsbf_pkg::ADDR_W-1:0]      ram_rd_addr,
    output lsbf_pkg::lsbf_ctrl_t             ctrl
);

    import lsbf_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_DRAIN = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic [K_W-1:0]    K_LAST   = K_W'(PANEL_WIDTH - 1);
    localparam logic [Y_W-1:0]    Y_LAST   = Y_W'(LINES_PER_STRIP - 1);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(STORE_DEPTH - 1);
    localparam logic [FCNT_W-1:0] F_LAST   = FCNT_W'(STRIP_COUNT - 1);
    localparam logic [BCNT_W-1:0] B_LAST   = BCNT_W'(COLOR_BITS - 1);

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] row_base_reg, row_base_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [Y_W-1:0]    y_reg, y_next;
    logic [FCNT_W-1:0] fcnt_reg, fcnt_next;
    logic [BCNT_W-1:0] bcnt_reg, bcnt_next;
    logic              lastf_reg, lastf_next;
    logic              rev_reg;
    logic              cap_reg;

    logic [K_W-1:0]    x;
    logic [SUM_W-1:0]  add_a, add_b, add_sum;
    logic              accept;

    assign x       = (y_reg[0] == rev_reg) ? k_reg : K_LAST - k_reg;
    assign add_sum = add_a + add_b;
    assign accept  = in_valid && in_ready;

    // shared address adder
    always_comb
    begin
        unique case (state_reg)
            ST_SETUP:
            begin
                add_a = SUM_W'(row_base_reg);
                add_b = SUM_W'(x);
            end
            ST_FETCH:
            begin
                add_a = SUM_W'(addr_reg);
                add_b = SUM_W'(STRIP_STRIDE);
            end
            default:
            begin
                add_a = SUM_W'(row_base_reg);
                add_b = SUM_W'(PANEL_WIDTH);
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        addr_next     = addr_reg;
        row_base_next = row_base_reg;
        k_next        = k_reg;
        y_next        = y_reg;
        fcnt_next     = fcnt_reg;
        bcnt_next     = bcnt_reg;
        lastf_next    = lastf_reg;
        in_ready      = 1'b0;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = ADDR_W'(in_index);
        ram_wr_data   = in_color;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = addr_reg;
        ctrl.capture       = cap_reg;
        ctrl.emit          = 1'b0;
        ctrl.last_of_group = (bcnt_reg == B_LAST);
        ctrl.last_of_frame = (bcnt_reg == B_LAST) && lastf_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
                clr_next    = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    if (in_kind)
                    begin
                        state_next = ST_SETUP;
                    end
                    else if (32'(in_index) < 32'(STORE_DEPTH))
                    begin
                        ram_wr_en = 1'b1;
                    end
                end
            end
            ST_SETUP:
            begin
                addr_next  = add_sum[ADDR_W-1:0];
                fcnt_next  = '0;
                lastf_next = (k_reg == K_LAST) && (y_reg == Y_LAST);
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                ram_rd_en = 1'b1;
                addr_next = add_sum[ADDR_W-1:0];
                fcnt_next = fcnt_reg + 1'b1;
                if (fcnt_reg == F_LAST)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                bcnt_next  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                ctrl.emit = 1'b1;
                if (can_load)
                begin
                    bcnt_next = bcnt_reg + 1'b1;
                    if (bcnt_reg == B_LAST)
                    begin
                        state_next = ST_IDLE;
                        if (k_reg == K_LAST)
                        begin
                            k_next = '0;
                            if (y_reg == Y_LAST)
                            begin
                                y_next        = '0;
                                row_base_next = '0;
                            end
                            else
                            begin
                                y_next        = y_reg + 1'b1;
                                row_base_next = add_sum[ADDR_W-1:0];
                            end
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            row_base_reg <= '0;
            k_reg        <= '0;
            y_reg        <= '0;
            fcnt_reg     <= '0;
            bcnt_reg     <= '0;
            lastf_reg    <= 1'b0;
            rev_reg      <= 1'b0;
            cap_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            row_base_reg <= row_base_next;
            k_reg        <= k_next;
            y_reg        <= y_next;
            fcnt_reg     <= fcnt_next;
            bcnt_reg     <= bcnt_next;
            lastf_reg    <= lastf_next;
            cap_reg      <= ram_rd_en;
            if (cfg_wr_en)
            begin
                rev_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

endmodule

`default_nettype wire

[rtl/core/lsbf_plane.sv]
`default_nettype none

module lsbf_plane (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire lsbf_pkg::lsbf_ctrl_t           ctrl,
    input  wire logic [lsbf_pkg::COLOR_BITS-1:0] rd_data,
    output logic                                can_load,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [lsbf_pkg::BYTE_BITS-1:0]      out_byte,
    output logic                                out_last_group,
    output logic                                out_last_frame
);

    import lsbf_pkg::*;

    color_t grb_reg [STRIP_COUNT];
    logic   valid_reg;
    logic   load;

    assign can_load  = !valid_reg || out_ready;
    assign load      = ctrl.emit && can_load;
    assign out_valid = valid_reg;

    // strip words fill from the top; after eight captures entry i is strip i
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            for (int i = 0; i < STRIP_COUNT - 1; i++)
            begin
                grb_reg[i] <= grb_reg[i+1];
            end
            grb_reg[STRIP_COUNT-1] <= to_grb(rd_data);
        end
        else if (load)
        begin
            for (int i = 0; i < STRIP_COUNT; i++)
            begin
                grb_reg[i] <= {grb_reg[i][COLOR_BITS-2:0], 1'b0};
            end
        end
        if (load)
        begin
            for (int i = 0; i < STRIP_COUNT; i++)
            begin
                out_byte[i] <= grb_reg[i][COLOR_BITS-1];
            end
            out_last_group <= ctrl.last_of_group;
            out_last_frame <= ctrl.last_of_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[tb/led_strip_bitplane_formatter_unit_test.sv]
module led_strip_bitplane_formatter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsbf_pkg::*;

    typedef enum bit {ITEM_PIXEL = 1'b0, ITEM_GROUP = 1'b1} item_kind_e;

    typedef struct packed {
        logic [BYTE_BITS-1:0] plane;
        logic                 group_end;
        logic                 frame_end;
    } plane_beat_t;

    localparam int unsigned QUIET_LIMIT   = 3000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES   = 400;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    color_t      pixel_mirror [STORE_DEPTH];
    int unsigned group_next = 0;
    bit          row_flip = 1'b0;
    plane_beat_t plane_expect [$];

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned sink_hold = 0;
    int unsigned quiet_cycles = 0;
    int          errors = 0;

    led_strip_bitplane_formatter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // store address of one strip's pixel in serpentine group g
    function automatic int unsigned fetch_addr(input int unsigned g, input int unsigned strip);
        int unsigned row;
        int unsigned step;
        int unsigned col;
        row  = g / PANEL_WIDTH;
        step = g % PANEL_WIDTH;
        col  = ((row & 1) == row_flip) ? step : PANEL_WIDTH - 1 - step;
        return col + (row + LINES_PER_STRIP * strip) * PANEL_WIDTH;
    endfunction

    task automatic predict_planes(input item_kind_e kind, input logic [INDEX_BITS-1:0] idx,
                                  input color_t col);
        color_t      grb [STRIP_COUNT];
        color_t      rgb;
        plane_beat_t beat;
        if (kind == ITEM_PIXEL)
        begin
            if (idx < STORE_DEPTH)
                pixel_mirror[idx] = col;
        end
        else
        begin
            for (int s = 0; s < STRIP_COUNT; s++)
            begin
                rgb    = pixel_mirror[fetch_addr(group_next, s)];
                grb[s] = {rgb[15:8], rgb[23:16], rgb[7:0]};
            end
            for (int b = 0; b < COLOR_BITS; b++)
            begin
                for (int s = 0; s < STRIP_COUNT; s++)
                    beat.plane[s] = grb[s][COLOR_BITS-1-b];
                beat.group_end = (b == COLOR_BITS - 1);
                beat.frame_end = beat.group_end && (group_next == STRIP_STRIDE - 1);
                plane_expect.push_back(beat);
            end
            group_next = (group_next == STRIP_STRIDE - 1) ? 0 : group_next + 1;
        end
    endtask

    task automatic push_item(input item_kind_e kind, input logic [INDEX_BITS-1:0] idx,
                             input color_t col);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, col, idx};
        s_axis_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_planes(kind, idx, col);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (plane_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_row_flip(input bit value);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        row_flip = value;
    endtask

    task automatic test_directed_colours();
        color_t shades [STRIP_COUNT];
        shades = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF,
                   24'h800001, 24'hA5C35A, 24'h5A3CA5, 24'h010080};
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        for (int s = 0; s < STRIP_COUNT; s++)
            push_item(ITEM_PIXEL, INDEX_BITS'(fetch_addr(group_next, s)), shades[s]);
        push_item(ITEM_GROUP, '0, '0);
        // out-of-range writes must leave the store alone
        push_item(ITEM_PIXEL, INDEX_BITS'(STORE_DEPTH), 24'hFFFFFF);
        push_item(ITEM_PIXEL, '1, 24'hFFFFFF);
        push_item(ITEM_PIXEL, INDEX_BITS'(STORE_DEPTH - 1), 24'hFFFFFF);
        push_item(ITEM_PIXEL, INDEX_BITS'(fetch_addr(group_next, STRIP_COUNT - 1)), 24'hFFFFFF);
        push_item(ITEM_PIXEL, INDEX_BITS'(fetch_addr(group_next, STRIP_COUNT - 1)), 24'h000000);
        push_item(ITEM_PIXEL, INDEX_BITS'(fetch_addr(group_next, 0)), 24'h123456);
        push_item(ITEM_GROUP, '1, '1);
        push_item(ITEM_GROUP, '0, '0);
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned src_pct,
                                       input int unsigned sink_pct);
        int unsigned pick;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
                push_item(ITEM_GROUP, INDEX_BITS'($urandom_range(1023)), color_t'($urandom));
            else if (pick < 85)
                push_item(ITEM_PIXEL,
                          INDEX_BITS'(fetch_addr(group_next, $urandom_range(STRIP_COUNT - 1))),
                          color_t'($urandom));
            else if (pick < 95)
                push_item(ITEM_PIXEL, INDEX_BITS'($urandom_range(STORE_DEPTH - 1)),
                          color_t'($urandom));
            else
                push_item(ITEM_PIXEL, INDEX_BITS'($urandom_range(1023, STORE_DEPTH)),
                          color_t'($urandom));
        end
    endtask

    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold      = HOLD_CYCLES;
        repeat (6)
        begin
            push_item(ITEM_PIXEL,
                      INDEX_BITS'(fetch_addr(group_next, $urandom_range(STRIP_COUNT - 1))),
                      color_t'($urandom));
            push_item(ITEM_GROUP, '0, '0);
        end
        wait_drain();
    endtask

    task automatic test_frame_wrap();
        src_idle_pct   = 0;
        sink_stall_pct = 20;
        do
            push_item(ITEM_GROUP, '0, '0);
        while (group_next != 0);
    endtask

    // sink side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (sink_hold != 0)
        begin
            sink_hold = sink_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        plane_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (plane_expect.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected item: byte %02h tlast %b tuser %b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            else
            begin
                want = plane_expect.pop_front();
                if (m_axis_tdata !== want.plane || m_axis_tlast !== want.group_end ||
                    m_axis_tuser !== want.frame_end)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected byte %02h tlast %b tuser %b, got %02h %b %b",
                                 want.plane, want.group_end, want.frame_end,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
            end
        end
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("led_strip_bitplane_formatter_unit_test: done, errors");
        $finish;
    end

    initial
    begin
        foreach (pixel_mirror[i])
            pixel_mirror[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        set_row_flip(1'b0);
        test_directed_colours();
        test_random_traffic(8, 0, 0);
        set_row_flip(1'b1);
        test_random_traffic(8, 72, 0);
        test_random_traffic(8, 0, 72);
        set_row_flip(1'b0);
        test_random_traffic(8, 20, 20);
        test_backpressure();
        set_row_flip(1'b1);
        test_frame_wrap();
        set_row_flip(1'b0);
        test_random_traffic(6, 20, 20);
        wait_drain();

        if (errors == 0 && plane_expect.size() == 0)
            $display("led_strip_bitplane_formatter_unit_test: done, clean");
        else
            $display("led_strip_bitplane_formatter_unit_test: done, errors");
        $finish;
    end

endmodule
